/* src/bcpu_pkg.sv */
package bcpu_pkg;

    localparam int MEM_ADDR_BITS = 16;
    localparam int MEM_DEPTH     = 1 << MEM_ADDR_BITS;
    localparam int REG_COUNT     = 16;
    localparam int REG_IDX_BITS  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    localparam logic [7:0] OP_MOV  = 8'd0;
    localparam logic [7:0] OP_LD   = 8'd1;
    localparam logic [7:0] OP_LDI  = 8'd2;
    localparam logic [7:0] OP_ST   = 8'd3;
    localparam logic [7:0] OP_STI  = 8'd4;
    localparam logic [7:0] OP_NOT  = 8'd5;
    localparam logic [7:0] OP_ADD  = 8'd6;
    localparam logic [7:0] OP_SUB  = 8'd7;
    localparam logic [7:0] OP_MUL  = 8'd8;
    localparam logic [7:0] OP_DIV  = 8'd9;
    localparam logic [7:0] OP_AND  = 8'd10;
    localparam logic [7:0] OP_OR   = 8'd11;
    localparam logic [7:0] OP_XOR  = 8'd12;
    localparam logic [7:0] OP_JMP  = 8'd13;
    localparam logic [7:0] OP_JZ   = 8'd14;
    localparam logic [7:0] OP_JNZ  = 8'd15;
    localparam logic [7:0] OP_NOP  = 8'd254;
    localparam logic [7:0] OP_HALT = 8'd255;

    localparam logic [1:0] STATUS_CONT    = 2'd0;
    localparam logic [1:0] STATUS_HALT    = 2'd1;
    localparam logic [1:0] STATUS_ILLEGAL = 2'd2;
    localparam logic [1:0] STATUS_DIVZERO = 2'd3;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV,
        ALU_AND,
        ALU_OR,
        ALU_XOR,
        ALU_NOT
    } alu_op_t;

    typedef struct packed {
        logic       start;
        alu_op_t    op;
        logic [7:0] x;
        logic [7:0] y;
    } alu_req_t;

    typedef struct packed {
        logic       done;
        logic [7:0] result;
    } alu_rsp_t;

endpackage

/* src/bcpu_alu.sv */
module bcpu_alu
    import bcpu_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [2:0] count_reg, count_next;
    logic [7:0] rem_reg, rem_next;
    logic [7:0] quot_reg, quot_next;
    logic [7:0] divisor_reg, divisor_next;
    logic [7:0] result_reg, result_next;

    logic [15:0] product;
    logic [8:0]  sum;
    logic [8:0]  diff;
    logic [7:0]  neg_diff;
    logic [7:0]  neg_mag;
    logic [7:0]  sub_result;
    logic [7:0]  quick_result;
    logic [8:0]  shifted;
    logic [9:0]  trial;
    logic        borrow;
    logic [7:0]  step_rem;
    logic [7:0]  step_quot;

    assign product  = req.x * req.y;
    assign sum      = {1'b0, req.x} + {1'b0, req.y};
    assign diff     = {1'b0, req.x} - {1'b0, req.y};
    assign neg_diff = req.y - req.x;
    assign neg_mag  = 8'd0 - {1'b0, neg_diff[6:0]};
    assign sub_result = diff[8] ? neg_mag : {1'b0, diff[6:0]};

    always_comb begin
        unique case (req.op)
            ALU_ADD: quick_result = {1'b0, sum[6:0]};
            ALU_SUB: quick_result = sub_result;
            ALU_MUL: quick_result = {1'b0, product[6:0]};
            ALU_AND: quick_result = req.x & req.y;
            ALU_OR:  quick_result = req.x | req.y;
            ALU_XOR: quick_result = req.x ^ req.y;
            ALU_NOT: quick_result = ~req.x;
            default: quick_result = 8'd0;
        endcase
    end

    // One restoring division step per cycle, quotient bits shifted in from the right.
    assign shifted   = {rem_reg, quot_reg[7]};
    assign trial     = {1'b0, shifted} - {2'b00, divisor_reg};
    assign borrow    = trial[9];
    assign step_rem  = borrow ? shifted[7:0] : trial[7:0];
    assign step_quot = {quot_reg[6:0], ~borrow};

    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        divisor_next = divisor_reg;
        result_next  = result_reg;
        if (busy_reg) begin
            rem_next   = step_rem;
            quot_next  = step_quot;
            count_next = count_reg + 3'd1;
            if (count_reg == 3'd7) begin
                busy_next   = 1'b0;
                done_next   = 1'b1;
                result_next = {1'b0, step_quot[6:0]};
            end
        end else if (req.start) begin
            if (req.op == ALU_DIV) begin
                busy_next    = 1'b1;
                count_next   = 3'd0;
                rem_next     = 8'd0;
                quot_next    = req.x;
                divisor_next = req.y;
            end else begin
                done_next   = 1'b1;
                result_next = quick_result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= 3'd0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        divisor_reg <= divisor_next;
        result_reg  <= result_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

/* src/byte_cpu_execute_step.sv */
// Each accepted word passes through the EXEC and WB states; ALU operations also wait in
// WAIT for the shared ALU's done, and DIV (but for a zero divisor) waits there while its
// bit-serial divider runs. The result word is registered when WB commits. The input is not
// ready while an instruction runs, so a new word is accepted only after the last commits.
// Reset clears the registers, the program counter and the zero flag, then sweeps the data
// memory to zero, during which no input word is accepted.
module byte_cpu_execute_step
    import bcpu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode[7:0], operand_a[15:8], operand_b[23:16], operand_c[31:24]
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // next_pc[15:0], status[17:16], zero_flag_out[18], reg_written[19], reg_index[23:20],
    // reg_value[31:24], mem_written[32], mem_address[48:33], mem_value[56:49], zero pad
    output logic [63:0] m_tdata
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_WAIT  = 5'b01000,
        S_WB    = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]  op_reg, a_reg, b_reg, c_reg;
    logic [7:0]  x_reg, y_reg;
    logic [7:0]  rdata_reg;
    logic [15:0] pc_reg;
    logic        zf_reg;
    logic [MEM_ADDR_BITS-1:0] clr_addr_reg;
    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg;

    logic [7:0]           rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] rf_valid_reg;
    logic [7:0]           dmem [MEM_DEPTH];

    logic        s_accept;
    logic        commit;
    logic [7:0]  in_op, in_b, in_c;
    logic [3:0]  x_idx, y_idx;
    logic        x_ok, y_ok;
    logic [7:0]  x_val, y_val;

    alu_req_t    alu_req;
    alu_rsp_t    alu_rsp;
    logic        alu_needed;

    logic [15:0] next_pc;
    logic [1:0]  status;
    logic        rw, mw;
    logic [7:0]  rval, mval;
    logic [MEM_ADDR_BITS-1:0] maddr;
    logic        zf_new;
    logic [3:0]  w_idx;
    logic        w_ok;

    logic [MEM_ADDR_BITS-1:0] mem_addr;
    logic        mem_we;
    logic [7:0]  mem_wdata;

    assign in_op = s_tdata[7:0];
    assign in_b  = s_tdata[23:16];
    assign in_c  = s_tdata[31:24];

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign commit   = (state_reg == S_WB) && (!m_tvalid_reg || m_tready);

    // Register 0 and indexes beyond the file read as zero.
    assign x_idx = in_b[3:0];
    assign y_idx = in_c[3:0];
    assign x_ok  = (x_idx != 4'd0) && ({1'b0, x_idx} < 5'(REG_COUNT))
                   && rf_valid_reg[x_idx[REG_IDX_BITS-1:0]];
    assign y_ok  = (y_idx != 4'd0) && ({1'b0, y_idx} < 5'(REG_COUNT))
                   && rf_valid_reg[y_idx[REG_IDX_BITS-1:0]];
    assign x_val = x_ok ? rf_mem[x_idx[REG_IDX_BITS-1:0]] : 8'd0;
    assign y_val = y_ok ? rf_mem[y_idx[REG_IDX_BITS-1:0]] : 8'd0;

    always_comb begin
        alu_req.op = ALU_ADD;
        alu_needed = 1'b1;
        unique case (op_reg)
            OP_NOT:  alu_req.op = ALU_NOT;
            OP_ADD:  alu_req.op = ALU_ADD;
            OP_SUB:  alu_req.op = ALU_SUB;
            OP_MUL:  alu_req.op = ALU_MUL;
            OP_DIV: begin
                alu_req.op = ALU_DIV;
                alu_needed = (y_reg != 8'd0);
            end
            OP_AND:  alu_req.op = ALU_AND;
            OP_OR:   alu_req.op = ALU_OR;
            OP_XOR:  alu_req.op = ALU_XOR;
            default: alu_needed = 1'b0;
        endcase
        alu_req.start = (state_reg == S_EXEC) && alu_needed;
        alu_req.x     = x_reg;
        alu_req.y     = y_reg;
    end

    bcpu_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .rsp     (alu_rsp)
    );

    always_comb begin
        next_pc = pc_reg;
        status  = STATUS_CONT;
        rw      = 1'b0;
        mw      = 1'b0;
        rval    = 8'd0;
        mval    = 8'd0;
        maddr   = '0;
        unique case (op_reg)
            OP_MOV: begin
                rw = 1'b1; rval = x_reg; next_pc = pc_reg + 16'd3;
            end
            OP_LD: begin
                rw = 1'b1; rval = rdata_reg; next_pc = pc_reg + 16'd4;
            end
            OP_LDI: begin
                rw = 1'b1; rval = b_reg; next_pc = pc_reg + 16'd3;
            end
            OP_ST: begin
                mw = 1'b1; mval = y_reg; next_pc = pc_reg + 16'd4;
                maddr = MEM_ADDR_BITS'({b_reg, a_reg});
            end
            OP_STI: begin
                mw = 1'b1; mval = c_reg; next_pc = pc_reg + 16'd4;
                maddr = MEM_ADDR_BITS'({b_reg, a_reg});
            end
            OP_NOT: begin
                rw = 1'b1; rval = alu_rsp.result; next_pc = pc_reg + 16'd3;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR: begin
                rw = 1'b1; rval = alu_rsp.result; next_pc = pc_reg + 16'd4;
            end
            OP_DIV: begin
                if (y_reg == 8'd0) begin
                    status = STATUS_DIVZERO;
                end else begin
                    rw = 1'b1; rval = alu_rsp.result; next_pc = pc_reg + 16'd4;
                end
            end
            OP_JMP:  next_pc = {8'd0, a_reg};
            OP_JZ:   next_pc = zf_reg ? {8'd0, a_reg} : pc_reg + 16'd2;
            OP_JNZ:  next_pc = zf_reg ? pc_reg + 16'd2 : {8'd0, a_reg};
            OP_NOP:  next_pc = pc_reg + 16'd2;
            OP_HALT: status = STATUS_HALT;
            default: status = STATUS_ILLEGAL;
        endcase
        zf_new = rw ? (rval == 8'd0) : zf_reg;
    end

    assign w_idx = a_reg[3:0];
    assign w_ok  = rw && (w_idx != 4'd0) && ({1'b0, w_idx} < 5'(REG_COUNT));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (&clr_addr_reg) state_next = S_IDLE;
            S_IDLE:  if (s_accept) state_next = S_EXEC;
            S_EXEC:  state_next = alu_needed ? S_WAIT : S_WB;
            S_WAIT:  if (alu_rsp.done) state_next = S_WB;
            S_WB:    if (commit) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            pc_reg       <= 16'd0;
            zf_reg       <= 1'b0;
            rf_valid_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (commit) begin
                pc_reg       <= next_pc;
                zf_reg       <= zf_new;
                m_tvalid_reg <= 1'b1;
                if (w_ok) begin
                    rf_valid_reg[w_idx[REG_IDX_BITS-1:0]] <= 1'b1;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg <= in_op;
            a_reg  <= s_tdata[15:8];
            b_reg  <= in_b;
            c_reg  <= in_c;
            x_reg  <= x_val;
            y_reg  <= y_val;
        end
        if (commit) begin
            if (w_ok) begin
                rf_mem[w_idx[REG_IDX_BITS-1:0]] <= rval;
            end
            m_tdata_reg <= {7'd0, mval, 16'(maddr), mw, rval, rw ? w_idx : 4'd0, rw,
                            zf_new, status, next_pc};
        end
    end

    // Single-port data memory shared by the clearing sweep, LD reads and stores.
    always_comb begin
        if (state_reg == S_CLEAR) begin
            mem_addr = clr_addr_reg;
        end else if (state_reg == S_WB) begin
            mem_addr = maddr;
        end else begin
            mem_addr = MEM_ADDR_BITS'({in_c, in_b});
        end
        mem_we    = (state_reg == S_CLEAR) || (commit && mw);
        mem_wdata = (state_reg == S_CLEAR) ? 8'd0 : mval;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            dmem[mem_addr] <= mem_wdata;
        end
        if (s_accept) begin
            rdata_reg <= dmem[mem_addr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
